/* rtl/core/plane_min_max_rms_statistics_defines.svh */
// Assertion macros shared by the RTL of the plane statistics block.
`ifndef PLANE_MIN_MAX_RMS_STATISTICS_DEFINES_SVH
`define PLANE_MIN_MAX_RMS_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMMRS_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmmrs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmmrs assertion failed");

`endif

/* rtl/core/pmmrs_pkg.sv */
package pmmrs_pkg;

	localparam int unsigned SW     = 24;
	localparam int unsigned CW     = 25;
	localparam int unsigned NW     = 12;
	localparam int unsigned SUMW   = 64;
	localparam int unsigned SQW    = 48;
	localparam int unsigned RMSW   = 23;
	localparam int unsigned ROOTW  = 32;
	localparam int unsigned STEP_W = 6;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned QPW     = $clog2(Q_DEPTH);
	localparam int unsigned QCW     = $clog2(Q_DEPTH + 1);

	localparam logic signed [SW-1:0] S_MAX   = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] S_MIN   = 24'sh800000;
	localparam logic [CW-1:0]        CNT_MAX = 25'h1FFFFFF;
	localparam logic [RMSW-1:0]      RMS_MAX = 23'h7FFFFF;

	localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
	localparam logic [STEP_W-1:0] ROOT_LAST = 6'd31;

	// One completed plane as it travels from the front to the back.
	typedef struct packed {
		logic [NW-1:0]          plane_number;
		logic signed [SW-1:0]   plane_low;
		logic signed [SW-1:0]   plane_high;
		logic                   is_final;
		logic signed [SW-1:0]   total_low;
		logic signed [SW-1:0]   total_high;
		logic [CW-1:0]          good_count;
		logic [CW-1:0]          blank_count;
		logic [SUMW-1:0]        square_sum;
	} rec_t;

	// One result as presented on the output channel.
	typedef struct packed {
		logic [NW-1:0]          plane_number;
		logic signed [SW-1:0]   plane_low;
		logic signed [SW-1:0]   plane_high;
		logic                   is_final;
		logic signed [SW-1:0]   total_low;
		logic signed [SW-1:0]   total_high;
		logic [CW-1:0]          good_count;
		logic [CW-1:0]          blank_count;
		logic [RMSW-1:0]        rms_value;
		logic                   no_valid;
		logic                   sum_saturated;
	} result_t;

	typedef struct packed {
		logic           empty;
		logic           full;
		logic [QCW-1:0] count;
	} q_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_ROOT,
		B_EMIT
	} back_state_t;

endpackage

/* rtl/core/pmmrs_queue.sv */
`include "plane_min_max_rms_statistics_defines.svh"

module pmmrs_queue import pmmrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rec_t      push_data,
	input  logic      pop,
	output rec_t      head,
	output q_status_t status
);

	rec_t            entry_q [Q_DEPTH];
	logic [QPW-1:0]  wr_ptr_q;
	logic [QPW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = entry_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCW'(Q_DEPTH));

	`PMMRS_ASSERT(q_no_overflow, clk, arst_n, push, count_q != QCW'(Q_DEPTH))
	`PMMRS_ASSERT(q_no_underflow, clk, arst_n, pop, count_q != '0)

endmodule

/* rtl/core/pmmrs_front.sv */
`include "plane_min_max_rms_statistics_defines.svh"

module pmmrs_front import pmmrs_pkg::*; #(
	parameter int unsigned MAX_PLANES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [SW-1:0] sample,
	input  logic                 is_blank,
	input  logic                 last,
	input  logic [CW-1:0]        plane_size,
	input  q_status_t            qs,
	output logic                 push,
	output rec_t                 push_data
);

	localparam int unsigned PCW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	logic                 s1_valid;
	logic signed [SW-1:0] sample_s1;
	logic                 blank_s1;
	logic                 last_s1;
	logic [SQW-1:0]       sq_s1;

	logic [CW-1:0]        in_plane_count_q, in_plane_count_d, cnt_u;
	logic [PCW-1:0]       plane_counter_q, plane_counter_d;
	logic signed [SW-1:0] plane_min_q, plane_min_d, plane_min_u;
	logic signed [SW-1:0] plane_max_q, plane_max_d, plane_max_u;
	logic signed [SW-1:0] global_min_q, global_min_d, global_min_u;
	logic signed [SW-1:0] global_max_q, global_max_d, global_max_u;
	logic [SUMW-1:0]      square_sum_q, square_sum_d, square_sum_u;
	logic [CW-1:0]        valid_total_q, valid_total_d, valid_total_u;
	logic [CW-1:0]        blank_total_q, blank_total_d, blank_total_u;

	logic [SW-1:0]        mag;
	logic [SUMW:0]        sum_ext;
	logic [CW-1:0]        size;
	logic [PCW+NW-1:0]    pc_ext;
	logic                 accept;

	// Two free slots cover the sample already sitting in stage one.
	assign in_ready = (qs.count <= QCW'(Q_DEPTH - 2));
	assign accept   = in_valid && in_ready;
	assign mag      = sample[SW-1] ? (~sample + 1'b1) : sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			blank_s1  <= is_blank;
			last_s1   <= last;
			sq_s1     <= SQW'(mag) * SQW'(mag);
		end
	end

	always_comb begin
		size    = (plane_size == '0) ? CW'(1) : plane_size;
		sum_ext = {1'b0, square_sum_q} + {{(SUMW-SQW+1){1'b0}}, sq_s1};
		pc_ext  = {{NW{1'b0}}, plane_counter_q};

		cnt_u         = in_plane_count_q;
		plane_min_u   = plane_min_q;
		plane_max_u   = plane_max_q;
		global_min_u  = global_min_q;
		global_max_u  = global_max_q;
		square_sum_u  = square_sum_q;
		valid_total_u = valid_total_q;
		blank_total_u = blank_total_q;

		if (s1_valid) begin
			if (blank_s1) begin
				if (blank_total_q != CNT_MAX) begin
					blank_total_u = blank_total_q + 1'b1;
				end
			end else begin
				if (sample_s1 < plane_min_q)  plane_min_u  = sample_s1;
				if (sample_s1 > plane_max_q)  plane_max_u  = sample_s1;
				if (sample_s1 < global_min_q) global_min_u = sample_s1;
				if (sample_s1 > global_max_q) global_max_u = sample_s1;
				square_sum_u = sum_ext[SUMW] ? '1 : sum_ext[SUMW-1:0];
				if (valid_total_q != CNT_MAX) begin
					valid_total_u = valid_total_q + 1'b1;
				end
			end
			if (in_plane_count_q != CNT_MAX) begin
				cnt_u = in_plane_count_q + 1'b1;
			end
		end

		push = s1_valid && (last_s1 || (cnt_u >= size));

		push_data              = '0;
		push_data.plane_number = pc_ext[NW-1:0];
		push_data.plane_low    = plane_min_u;
		push_data.plane_high   = plane_max_u;
		if (last_s1) begin
			push_data.is_final    = 1'b1;
			push_data.total_low   = global_min_u;
			push_data.total_high  = global_max_u;
			push_data.good_count  = valid_total_u;
			push_data.blank_count = blank_total_u;
			push_data.square_sum  = square_sum_u;
		end

		in_plane_count_d = cnt_u;
		plane_counter_d  = plane_counter_q;
		plane_min_d      = plane_min_u;
		plane_max_d      = plane_max_u;
		global_min_d     = global_min_u;
		global_max_d     = global_max_u;
		square_sum_d     = square_sum_u;
		valid_total_d    = valid_total_u;
		blank_total_d    = blank_total_u;

		if (push) begin
			in_plane_count_d = '0;
			plane_min_d      = S_MAX;
			plane_max_d      = S_MIN;
			if (last_s1) begin
				plane_counter_d = '0;
				global_min_d    = S_MAX;
				global_max_d    = S_MIN;
				square_sum_d    = '0;
				valid_total_d   = '0;
				blank_total_d   = '0;
			end else if (plane_counter_q == PCW'(MAX_PLANES - 1)) begin
				plane_counter_d = '0;
			end else begin
				plane_counter_d = plane_counter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_plane_count_q <= '0;
			plane_counter_q  <= '0;
			plane_min_q      <= S_MAX;
			plane_max_q      <= S_MIN;
			global_min_q     <= S_MAX;
			global_max_q     <= S_MIN;
			square_sum_q     <= '0;
			valid_total_q    <= '0;
			blank_total_q    <= '0;
		end else begin
			in_plane_count_q <= in_plane_count_d;
			plane_counter_q  <= plane_counter_d;
			plane_min_q      <= plane_min_d;
			plane_max_q      <= plane_max_d;
			global_min_q     <= global_min_d;
			global_max_q     <= global_max_d;
			square_sum_q     <= square_sum_d;
			valid_total_q    <= valid_total_d;
			blank_total_q    <= blank_total_d;
		end
	end

	`PMMRS_ASSERT_NEXT(fe_clear_after_last, clk, arst_n, s1_valid && last_s1,
		(valid_total_q == '0) && (in_plane_count_q == '0) && (square_sum_q == '0))

endmodule

/* rtl/core/pmmrs_back.sv */
`include "plane_min_max_rms_statistics_defines.svh"

module pmmrs_back import pmmrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t qs,
	input  rec_t      head,
	output logic      pop,
	input  logic      out_ready,
	output logic      out_valid,
	output result_t   out_data
);

	back_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [SUMW-1:0]   work_q;
	logic [CW-1:0]     rem_div_q;
	logic [ROOTW-1:0]  root_q;
	logic [ROOTW:0]    rem_root_q;
	rec_t              rec_q;
	result_t           out_q;
	logic              out_valid_q;

	logic              out_free;
	logic              load_plain;
	logic              load_final;
	logic              take_final;

	logic [CW:0]       div_sh;
	logic [CW:0]       div_d;
	logic              div_bit;
	logic [CW:0]       div_rem;
	logic [ROOTW+2:0]  root_sh;
	logic [ROOTW+2:0]  root_trial;
	logic              root_bit;
	logic [ROOTW+2:0]  root_rem;

	assign out_free = !out_valid_q || out_ready;

	// Restoring divide, one quotient bit per cycle.
	assign div_sh  = {rem_div_q, work_q[SUMW-1]};
	assign div_d   = {1'b0, rec_q.good_count};
	assign div_bit = (div_sh >= div_d);
	assign div_rem = div_bit ? (div_sh - div_d) : div_sh;

	// Digit-by-digit square root, one root bit per cycle.
	assign root_sh    = {rem_root_q, work_q[SUMW-1:SUMW-2]};
	assign root_trial = {1'b0, root_q, 2'b01};
	assign root_bit   = (root_sh >= root_trial);
	assign root_rem   = root_bit ? (root_sh - root_trial) : root_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load_plain = 1'b0;
		load_final = 1'b0;
		take_final = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!qs.empty) begin
					if (head.is_final) begin
						pop        = 1'b1;
						take_final = 1'b1;
						state_d    = (head.good_count == '0) ? B_EMIT : B_DIV;
					end else if (out_free) begin
						pop        = 1'b1;
						load_plain = 1'b1;
					end
				end
			end
			B_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = B_ROOT;
				end
			end
			B_ROOT: begin
				if (step_q == ROOT_LAST) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (out_free) begin
					load_final = 1'b1;
					state_d    = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_plain || load_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_final || ((state_q == B_ROOT) && (step_q == ROOT_LAST))) begin
				step_q <= '0;
			end else if ((state_q == B_DIV) || (state_q == B_ROOT)) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_final) begin
			rec_q     <= head;
			work_q    <= head.square_sum;
			rem_div_q <= '0;
		end
		if (state_q == B_DIV) begin
			work_q    <= {work_q[SUMW-2:0], div_bit};
			rem_div_q <= div_rem[CW-1:0];
			if (step_q == DIV_LAST) begin
				root_q     <= '0;
				rem_root_q <= '0;
			end
		end
		if (state_q == B_ROOT) begin
			work_q     <= {work_q[SUMW-3:0], 2'b00};
			root_q     <= {root_q[ROOTW-2:0], root_bit};
			rem_root_q <= root_rem[ROOTW:0];
		end
		if (load_plain) begin
			out_q.plane_number  <= head.plane_number;
			out_q.plane_low     <= head.plane_low;
			out_q.plane_high    <= head.plane_high;
			out_q.is_final      <= 1'b0;
			out_q.total_low     <= '0;
			out_q.total_high    <= '0;
			out_q.good_count    <= '0;
			out_q.blank_count   <= '0;
			out_q.rms_value     <= '0;
			out_q.no_valid      <= 1'b0;
			out_q.sum_saturated <= 1'b0;
		end
		if (load_final) begin
			out_q.plane_number  <= rec_q.plane_number;
			out_q.plane_low     <= rec_q.plane_low;
			out_q.plane_high    <= rec_q.plane_high;
			out_q.is_final      <= 1'b1;
			out_q.total_low     <= rec_q.total_low;
			out_q.total_high    <= rec_q.total_high;
			out_q.good_count    <= rec_q.good_count;
			out_q.blank_count   <= rec_q.blank_count;
			out_q.no_valid      <= (rec_q.good_count == '0);
			out_q.sum_saturated <= (rec_q.square_sum == '1);
			if (rec_q.good_count == '0) begin
				out_q.rms_value <= '0;
			end else if (root_q > ROOTW'(RMS_MAX)) begin
				out_q.rms_value <= RMS_MAX;
			end else begin
				out_q.rms_value <= root_q[RMSW-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PMMRS_ASSERT(bk_div_nonzero, clk, arst_n, state_q == B_DIV, rec_q.good_count != '0)
	`PMMRS_ASSERT(bk_pop_idle, clk, arst_n, pop, state_q == B_IDLE)
	`PMMRS_ASSERT(bk_load_free, clk, arst_n, load_plain || load_final, out_free)

endmodule

/* rtl/core/plane_min_max_rms_statistics.sv */
// Per-plane and global minimum, maximum and RMS statistics over a data cube.
// Samples arrive on the input channel (in_valid/in_ready) in raster order, one
// request per sample, with a blank flag and a flag on the final sample.
// A result request leaves on the output channel (out_valid/out_ready) each time
// plane_size samples complete a plane, and for the sample flagged last.
// The user must write plane_size through plane_size_we only while the block is idle; the block does not enforce it.
// Throughput is one sample per cycle while in_ready is high; a closing sample
// passes the stage-one register, then the queue, then the output register.
// The final record takes a restoring divide of the square sum by the good count,
// a square root of the quotient and a load of the output register; when no
// sample was valid the divide and the root are skipped.
// Meanwhile the four-entry queue keeps taking plane records; with one-sample
// planes four further samples get in before in_ready falls.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops until results are taken again.
// Reset clears every statistic, sets plane_size to one and empties the queue.
module plane_min_max_rms_statistics import pmmrs_pkg::*; #(
	parameter int unsigned MAX_PLANES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 plane_size_we,
	input  logic [CW-1:0]        plane_size,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [SW-1:0] sample,
	input  logic                 is_blank,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NW-1:0]        plane_number,
	output logic signed [SW-1:0] plane_low,
	output logic signed [SW-1:0] plane_high,
	output logic                 is_final,
	output logic signed [SW-1:0] total_low,
	output logic signed [SW-1:0] total_high,
	output logic [CW-1:0]        good_count,
	output logic [CW-1:0]        blank_count,
	output logic [RMSW-1:0]      rms_value,
	output logic                 no_valid,
	output logic                 sum_saturated
);

	logic [CW-1:0] plane_size_q;
	q_status_t     qs;
	logic          push;
	rec_t          push_data;
	logic          pop;
	rec_t          head;
	result_t       out_data;

	// The plane size register; a value of zero is treated as one downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_size_q <= CW'(1);
		end else if (plane_size_we) begin
			plane_size_q <= plane_size;
		end
	end

	// The front end squares each sample, updates the running statistics and
	// queues a record whenever a plane closes.
	pmmrs_front #(
		.MAX_PLANES(MAX_PLANES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.is_blank   (is_blank),
		.last       (last),
		.plane_size (plane_size_q),
		.qs         (qs),
		.push       (push),
		.push_data  (push_data)
	);

	// The queue decouples the sample stream from the slow final computation.
	pmmrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (qs)
	);

	// The back end forwards plane records and works out the RMS of the final one.
	pmmrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qs        (qs),
		.head      (head),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign plane_number  = out_data.plane_number;
	assign plane_low     = out_data.plane_low;
	assign plane_high    = out_data.plane_high;
	assign is_final      = out_data.is_final;
	assign total_low     = out_data.total_low;
	assign total_high    = out_data.total_high;
	assign good_count    = out_data.good_count;
	assign blank_count   = out_data.blank_count;
	assign rms_value     = out_data.rms_value;
	assign no_valid      = out_data.no_valid;
	assign sum_saturated = out_data.sum_saturated;

endmodule
